// ===== rtl/light_sample_moving_average_defines.svh =====
// Assertion macros shared by the light sample moving average RTL.
`ifndef LIGHT_SAMPLE_MOVING_AVERAGE_DEFINES_SVH
`define LIGHT_SAMPLE_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LSMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsma assertion failed");

// Next-cycle implication.
`define LSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsma assertion failed");

`else

`define LSMA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lsma_pkg.sv =====
package lsma_pkg;

    localparam int RAW_W  = 16;
    localparam int LUX_W  = 20;
    localparam int USED_W = 4;

    typedef logic [RAW_W-1:0]  t_raw;
    typedef logic [LUX_W-1:0]  t_lux;
    typedef logic [USED_W-1:0] t_used;

endpackage

// ===== rtl/lsma_ram.sv =====
module lsma_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/light_sample_moving_average.sv =====
// Per accepted word the sequencer subtracts the oldest sample once the window is full,
// adds the new one, scales and divides; only one word is in flight, and the result waits
// while the output register is full. The restoring divider retires one quotient bit per cycle over
// DIV_W = sum width + 6 bits. Reset (i_rst_n low, synchronous): sequencer idle, ring
// position, fill count, running sum cleared, no result pending; ring undefined until written.
`include "light_sample_moving_average_defines.svh"

module light_sample_moving_average #(
    parameter int WINDOW = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lsma_pkg::t_raw        i_raw_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lsma_pkg::t_lux        o_filtered_lux,
    output lsma_pkg::t_used       o_samples_used
);

    import lsma_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = RAW_W + $clog2(WINDOW);
    localparam int DIV_W  = SUM_W + 6;
    localparam int DVS_W  = CNT_W + 2;
    localparam int BIT_W  = $clog2(DIV_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state,  n_state;
    logic [SLOT_W-1:0] r_slot,  n_slot;
    logic [CNT_W-1:0] r_fill,   n_fill;
    logic [SUM_W-1:0] r_sum,    n_sum;
    logic [RAW_W-1:0] r_sample, n_sample;
    logic [DIV_W-1:0] r_quo,    n_quo;
    logic [DVS_W-1:0] r_rem,    n_rem;
    logic [DVS_W-1:0] r_dvs,    n_dvs;
    logic [BIT_W-1:0] r_bit,    n_bit;
    logic             r_out_valid, n_out_valid;
    t_lux             r_lux,    n_lux;
    logic [CNT_W-1:0] r_used,   n_used;

    logic             in_take;
    logic             ram_we;
    logic [RAW_W-1:0] ram_rdata;
    logic             full;
    logic [DVS_W:0]   div_shift;
    logic [DVS_W+1:0] div_diff;
    logic             div_ge;

    assign in_take = i_valid && o_ready;
    assign full    = (r_fill == CNT_W'(WINDOW));
    assign ram_we  = (r_state == S_ADD);

    lsma_ram #(
        .WIDTH (RAW_W),
        .DEPTH (WINDOW),
        .ADDR_W(SLOT_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(r_sample),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    // Shared trial subtractor of the restoring divider.
    assign div_shift = {r_rem, r_quo[DIV_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, r_dvs};
    assign div_ge    = !div_diff[DVS_W+1];

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_sample    = r_sample;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        n_lux       = r_lux;
        n_used      = r_used;

        // drop the result word once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_sample = i_raw_count;
                    n_state  = S_SUB;
                end
            end
            S_SUB: begin
                // ring read of the oldest sample lands this cycle
                if (full) begin
                    n_sum = r_sum - SUM_W'(ram_rdata);
                end else begin
                    n_fill = r_fill + CNT_W'(1);
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum   = r_sum + SUM_W'(r_sample);
                n_slot  = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                n_state = S_MUL;
            end
            S_MUL: begin
                // sum * 40 over fill * 3
                n_quo   = (DIV_W'(r_sum) << 5) + (DIV_W'(r_sum) << 3);
                n_dvs   = (DVS_W'(r_fill) << 1) + DVS_W'(r_fill);
                n_rem   = '0;
                n_bit   = BIT_W'(DIV_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], div_ge};
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_lux       = r_quo[LUX_W-1:0];
                    n_used      = r_fill;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_sample <= n_sample;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_bit    <= n_bit;
        r_lux    <= n_lux;
        r_used   <= n_used;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_filtered_lux = r_lux;
    assign o_samples_used = USED_W'(r_used);

    `LSMA_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(WINDOW))
    `LSMA_ASSERT_NOW(a_used_nonzero, i_clk, i_rst_n, o_valid, r_used != '0)
    `LSMA_ASSERT_NOW(a_rem_below_dvs, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_dvs)
    `LSMA_ASSERT_NEXT(a_sum_idle_hold, i_clk, i_rst_n, (r_state == S_IDLE) && !in_take, $stable(r_sum))

endmodule
